// ===== src/chm_pkg.sv =====
// Package for the chained hash identifier map.
// Holds operation codes, controller states and the command and status structs.
// No dependencies.
package chm_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_HEAD_LD,
        ST_CMP,
        ST_HIT,
        ST_RELEASE,
        ST_MISS,
        ST_ALLOC_FREE,
        ST_RES
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_HEAD_RD,
        DP_HEAD_LD,
        DP_ADVANCE,
        DP_UPD,
        DP_FREE_RD,
        DP_ALLOC_FREE,
        DP_ALLOC_FRESH,
        DP_UNLINK,
        DP_RELEASE,
        DP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_ld;
        logic   found;
        logic   full;
        logic   show;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       hash_done;
        logic       head_null;
        logic       key_match;
        logic       link_null;
        logic       walk_last;
        logic       free_valid;
        logic       fresh_avail;
    } dp_status_t;

endpackage

// ===== src/chm_mod.sv =====
// Remainder unit: key mod BUCKET_COUNT by reciprocal multiplication in registered steps.
// Depends on chm_pkg.
module chm_mod #(
    parameter int BUCKET_COUNT = 101,
    parameter int BKT_W        = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [chm_pkg::KEY_W-1:0] din,
    output logic                     done,
    output logic [BKT_W-1:0]         rem
);
    import chm_pkg::*;

    // (key * RECIP) >> SHIFT equals key / BUCKET_COUNT or falls one short of it
    localparam int FLOOR_LOG2 = $clog2(BUCKET_COUNT + 1) - 1;
    localparam int SHIFT      = 31 + FLOOR_LOG2;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << SHIFT) / 64'(BUCKET_COUNT));
    localparam logic [KEY_W-1:0] B     = KEY_W'(BUCKET_COUNT);

    logic [KEY_W-1:0]   din_reg, din_next;
    logic [2*KEY_W-1:0] prod_reg, prod_next;
    logic [KEY_W-1:0]   qd_reg, qd_next;
    logic [BKT_W-1:0]   r_reg, r_next;
    logic [2:0]         stage_reg, stage_next;
    logic               done_reg, done_next;
    logic [KEY_W-1:0]   quo;
    logic [KEY_W-1:0]   diff;

    always_comb
    begin
        quo  = KEY_W'(prod_reg >> SHIFT);
        diff = din_reg - qd_reg;
        // the quotient estimate is at most one short: one correction step
        if (diff >= B)
        begin
            diff = diff - B;
        end
        din_next   = din_reg;
        prod_next  = prod_reg;
        qd_next    = qd_reg;
        r_next     = r_reg;
        stage_next = stage_reg;
        done_next  = done_reg;
        if (start)
        begin
            din_next   = din;
            stage_next = 3'b001;
            done_next  = 1'b0;
        end
        else
        begin
            stage_next = {stage_reg[1:0], 1'b0};
            if (stage_reg[0])
            begin
                prod_next = {{KEY_W{1'b0}}, din_reg} * {{KEY_W{1'b0}}, RECIP};
            end
            if (stage_reg[1])
            begin
                qd_next = KEY_W'(quo * B);
            end
            if (stage_reg[2])
            begin
                r_next    = diff[BKT_W-1:0];
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b1;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        din_reg  <= din_next;
        prod_reg <= prod_next;
        qd_reg   <= qd_next;
        r_reg    <= r_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ===== src/chm_dp.sv =====
// Datapath of the hash map: bucket and entry memories, walk registers,
// pool bookkeeping and the result register. Depends on chm_pkg and chm_mod.
module chm_dp #(
    parameter int BUCKET_COUNT = 101,
    parameter int POOL_ENTRIES = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  chm_pkg::dp_cmd_t             cmd,
    output chm_pkg::dp_status_t          status,
    input  logic [1:0]                   in_mode,
    input  logic [chm_pkg::KEY_W-1:0]    in_key,
    input  logic [chm_pkg::VALUE_W-1:0]  in_value,
    output logic                         res_found,
    output logic [chm_pkg::VALUE_W-1:0]  res_value,
    output logic                         res_full
);
    import chm_pkg::*;

    localparam int IDX_W  = $clog2(POOL_ENTRIES + 1);
    localparam int ADDR_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_ENTRIES);

    logic [KEY_W-1:0]   key_mem  [POOL_ENTRIES];
    logic [VALUE_W-1:0] val_mem  [POOL_ENTRIES];
    logic [IDX_W-1:0]   link_mem [POOL_ENTRIES];
    logic [IDX_W-1:0]   bkt_mem  [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] bkt_vld_reg;

    logic [1:0]         mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [BKT_W-1:0]   bkt_idx_reg;
    logic [IDX_W-1:0]   cur_reg, prev_reg, steps_reg, head_reg;
    logic [IDX_W-1:0]   free_head_reg, fresh_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;
    logic [IDX_W-1:0]   link_rd_reg, bkt_rd_reg;
    logic               bkt_vld_rd_reg;
    logic               found_reg, full_reg;
    logic [VALUE_W-1:0] rdval_reg;

    logic               hash_done;
    logic [BKT_W-1:0]   hash_rem;
    logic [IDX_W-1:0]   head_eff, new_idx;
    logic               ent_rd_en, ent_wr_en, val_wr_en, link_wr_en, bkt_wr_en;
    logic [IDX_W-1:0]   ent_rd_addr, ent_wr_addr, val_wr_addr, link_wr_addr;
    logic [IDX_W-1:0]   link_wr_data, bkt_wr_data;

    chm_mod #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BKT_W        (BKT_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == DP_START),
        .din   (in_key),
        .done  (hash_done),
        .rem   (hash_rem)
    );

    assign head_eff = (bkt_vld_rd_reg && bkt_rd_reg < NULL_IDX) ? bkt_rd_reg : NULL_IDX;
    assign new_idx  = (cmd.op == DP_ALLOC_FREE) ? free_head_reg : fresh_reg;

    always_comb
    begin
        ent_rd_en    = 1'b0;
        ent_rd_addr  = head_eff;
        ent_wr_en    = 1'b0;
        ent_wr_addr  = new_idx;
        val_wr_en    = 1'b0;
        val_wr_addr  = new_idx;
        link_wr_en   = 1'b0;
        link_wr_addr = new_idx;
        link_wr_data = head_reg;
        bkt_wr_en    = 1'b0;
        bkt_wr_data  = new_idx;
        case (cmd.op)
            DP_HEAD_LD:
            begin
                ent_rd_en   = (head_eff != NULL_IDX);
                ent_rd_addr = head_eff;
            end
            DP_ADVANCE:
            begin
                ent_rd_en   = 1'b1;
                ent_rd_addr = link_rd_reg;
            end
            DP_FREE_RD:
            begin
                ent_rd_en   = 1'b1;
                ent_rd_addr = free_head_reg;
            end
            DP_UPD:
            begin
                val_wr_en   = 1'b1;
                val_wr_addr = cur_reg;
            end
            DP_ALLOC_FREE, DP_ALLOC_FRESH:
            begin
                ent_wr_en  = 1'b1;
                val_wr_en  = 1'b1;
                link_wr_en = 1'b1;
                bkt_wr_en  = 1'b1;
            end
            DP_UNLINK:
            begin
                // bypass the hit entry: predecessor link or bucket head
                if (prev_reg != NULL_IDX)
                begin
                    link_wr_en   = 1'b1;
                    link_wr_addr = prev_reg;
                    link_wr_data = link_rd_reg;
                end
                else
                begin
                    bkt_wr_en   = 1'b1;
                    bkt_wr_data = link_rd_reg;
                end
            end
            DP_RELEASE:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = free_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            key_mem[ent_wr_addr[ADDR_W-1:0]] <= key_reg;
        end
        if (val_wr_en)
        begin
            val_mem[val_wr_addr[ADDR_W-1:0]] <= value_reg;
        end
        if (link_wr_en)
        begin
            link_mem[link_wr_addr[ADDR_W-1:0]] <= link_wr_data;
        end
        if (ent_rd_en)
        begin
            key_rd_reg  <= key_mem[ent_rd_addr[ADDR_W-1:0]];
            val_rd_reg  <= val_mem[ent_rd_addr[ADDR_W-1:0]];
            link_rd_reg <= link_mem[ent_rd_addr[ADDR_W-1:0]];
        end
        if (bkt_wr_en)
        begin
            bkt_mem[bkt_idx_reg] <= bkt_wr_data;
        end
        if (cmd.op == DP_HEAD_RD)
        begin
            bkt_rd_reg     <= bkt_mem[hash_rem];
            bkt_vld_rd_reg <= bkt_vld_reg[hash_rem];
            bkt_idx_reg    <= hash_rem;
        end
    end

    // walk and operand registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_START:
            begin
                mode_reg  <= in_mode;
                key_reg   <= in_key;
                value_reg <= in_value;
            end
            DP_HEAD_RD:
            begin
                prev_reg  <= NULL_IDX;
                steps_reg <= '0;
            end
            DP_HEAD_LD:
            begin
                head_reg <= head_eff;
                cur_reg  <= head_eff;
            end
            DP_ADVANCE:
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= link_rd_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (cmd.res_ld)
        begin
            found_reg <= cmd.found;
            full_reg  <= cmd.full;
            rdval_reg <= cmd.show ? val_rd_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_vld_reg   <= '0;
            free_head_reg <= NULL_IDX;
            fresh_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR:
                begin
                    bkt_vld_reg   <= '0;
                    free_head_reg <= NULL_IDX;
                    fresh_reg     <= '0;
                end
                DP_ALLOC_FREE:
                begin
                    free_head_reg <= link_rd_reg;
                end
                DP_ALLOC_FRESH:
                begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
                DP_RELEASE:
                begin
                    free_head_reg <= cur_reg;
                end
                default:
                begin
                end
            endcase
            if (bkt_wr_en)
            begin
                bkt_vld_reg[bkt_idx_reg] <= 1'b1;
            end
        end
    end

    assign status.mode        = mode_reg;
    assign status.hash_done   = hash_done;
    assign status.head_null   = (head_eff == NULL_IDX);
    assign status.key_match   = (key_rd_reg == key_reg);
    assign status.link_null   = (link_rd_reg >= NULL_IDX);
    assign status.walk_last   = (steps_reg == IDX_W'(POOL_ENTRIES - 1));
    assign status.free_valid  = (free_head_reg < NULL_IDX);
    assign status.fresh_avail = (fresh_reg < NULL_IDX);

    assign res_found = found_reg;
    assign res_value = rdval_reg;
    assign res_full  = full_reg;

endmodule

// ===== src/chm_ctrl.sv =====
// Controller of the hash map: sequences hash, chain walk and update.
// Depends on chm_pkg.
module chm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output chm_pkg::dp_cmd_t    cmd,
    input  chm_pkg::dp_status_t status
);
    import chm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        hit_reg, hit_next;
    logic        full_reg, full_next;
    logic        mval_reg, mval_next;
    logic        out_free;

    assign out_free = !mval_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        mval_next  = mval_reg && !m_tready;
        s_tready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.res_ld = 1'b0;
        cmd.found  = hit_reg;
        cmd.full   = full_reg;
        cmd.show   = hit_reg && (status.mode == MODE_LOOKUP);
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = DP_START;
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (status.mode == MODE_CLEAR)
                begin
                    cmd.op     = DP_CLEAR;
                    state_next = ST_RES;
                end
                else if (status.hash_done)
                begin
                    cmd.op     = DP_HEAD_RD;
                    state_next = ST_HEAD_LD;
                end
            end
            ST_HEAD_LD:
            begin
                cmd.op     = DP_HEAD_LD;
                state_next = status.head_null ? ST_MISS : ST_CMP;
            end
            ST_CMP:
            begin
                if (status.key_match)
                begin
                    state_next = ST_HIT;
                end
                else if (status.link_null || status.walk_last)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.op = DP_ADVANCE;
                end
            end
            ST_HIT:
            begin
                hit_next   = 1'b1;
                state_next = ST_RES;
                case (status.mode)
                    MODE_INSERT:
                    begin
                        cmd.op = DP_UPD;
                    end
                    MODE_REMOVE:
                    begin
                        cmd.op     = DP_UNLINK;
                        state_next = ST_RELEASE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RELEASE:
            begin
                cmd.op     = DP_RELEASE;
                state_next = ST_RES;
            end
            ST_MISS:
            begin
                state_next = ST_RES;
                if (status.mode == MODE_INSERT)
                begin
                    if (status.free_valid)
                    begin
                        cmd.op     = DP_FREE_RD;
                        state_next = ST_ALLOC_FREE;
                    end
                    else if (status.fresh_avail)
                    begin
                        cmd.op = DP_ALLOC_FRESH;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            ST_ALLOC_FREE:
            begin
                cmd.op     = DP_ALLOC_FREE;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.res_ld = 1'b1;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hit_reg   <= 1'b0;
            full_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            full_reg  <= full_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_tvalid = mval_reg;

endmodule

// ===== src/chained_hash_id_map.sv =====
// Top level of the chained hash identifier map: controller plus datapath.
// Depends on chm_pkg, chm_ctrl, chm_dp.
//
//  channel | dir | ports                        | contents
//  s_*     | in  | s_tvalid s_tready s_tuser/tdata | mode; key, value
//  m_*     | out | m_tvalid m_tready m_tdata    | found, read_value, full_res
//
// One item at a time: the accept, key mod BUCKET_COUNT in the remainder unit
// (reciprocal multiply, quotient times divisor, subtract), the bucket head read,
// a compare of each chain entry in turn on the entry memory read port, the
// decide and update states and the result. Clear skips the hash and the walk
// and goes straight to the result.
// Reset clears the bucket valid bits at once; there is no clearing pass.
// The output register holds a result while the next item is accepted; the result
// cycle stalls while that register still holds an untaken beat.
module chained_hash_id_map #(
    parameter int BUCKET_COUNT = 101,
    parameter int POOL_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] found, [32:1] read_value, [33] full_res, pad
);
    import chm_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               res_found, res_full;
    logic [VALUE_W-1:0] res_value;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    chm_dp #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .res_found (res_found),
        .res_value (res_value),
        .res_full  (res_full)
    );

    assign m_tdata = {6'd0, res_full, res_value, res_found};

endmodule

// ===== src/chm_checker.sv =====
// Port-level checker for the chained hash identifier map, bound to the top.
// Depends on chained_hash_id_map only through its ports.
module chm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a result waiting to be taken stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: no accept in the cycle after an accept
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a value only comes with a hit
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] || m_tdata[32:1] == 32'd0))
        else $error("read value without hit");

    // a hit and a full pool are exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
        else $error("found and full together");

endmodule

bind chained_hash_id_map chm_checker u_chm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
